// ===== hdl/smx_pkg.sv =====
package smx_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned MEM_WORDS   = 256;
  localparam int unsigned DATA_WIDTH  = 32;

  localparam int unsigned OPC_W   = 4;
  localparam int unsigned OPND_W  = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned TOP_W   = 32;
  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SKIP_W  = 31;
  localparam int unsigned MEM_AW  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [MEM_AW-1:0]     maddr_t;

  localparam word_t MEM_LIMIT  = DATA_WIDTH'(MEM_WORDS);
  localparam cnt_t  STACK_FULL = CNT_W'(STACK_DEPTH);

  typedef enum logic [OPC_W-1:0] {
    OP_HALT  = 4'd0,
    OP_ADD   = 4'd1,
    OP_NOR   = 4'd2,
    OP_IFZ   = 4'd3,
    OP_LOAD  = 4'd4,
    OP_STORE = 4'd5,
    OP_POP   = 4'd6,
    OP_PUSHI = 4'd7,
    OP_NOOP  = 4'd8
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_SKIPPED   = 3'd1,
    ST_HALTED    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_BADADDR   = 3'd5,
    ST_IGNORED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP1,
    STK_POP2,
    STK_REPL,
    STK_MERGE
  } stk_op_e;

  typedef struct packed {
    stk_op_e op;
    word_t   val;
  } stk_cmd_t;

  typedef struct packed {
    logic   we;
    maddr_t addr;
    word_t  data;
  } mem_wr_t;

endpackage

// ===== hdl/smx_ram.sv =====
module smx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/smx_dmem.sv =====
module smx_dmem (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  smx_pkg::mem_wr_t wr_i,
  input  smx_pkg::maddr_t raddr_i,
  output smx_pkg::word_t  rdata_o
);
  import smx_pkg::*;

  logic [MEM_WORDS-1:0] vld_q;
  logic                 vld_rd_q;
  logic                 fwd_q;
  word_t                fwd_data_q;
  word_t                ram_rdata;
  logic                 hit;

  assign hit = wr_i.we && (wr_i.addr == raddr_i);

  smx_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_i.we),
    .waddr_i(wr_i.addr),
    .wdata_i(wr_i.data),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      vld_rd_q <= vld_q[raddr_i];
      fwd_q    <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_i.data;
  end

  assign rdata_o = fwd_q ? fwd_data_q : (vld_rd_q ? ram_rdata : '0);

endmodule

// ===== hdl/smx_stack.sv =====
module smx_stack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smx_pkg::stk_cmd_t cmd_i,
  output smx_pkg::word_t    top_o,
  output smx_pkg::word_t    second_o,
  output smx_pkg::cnt_t     cnt_o,
  output smx_pkg::word_t    top_next_o,
  output smx_pkg::cnt_t     cnt_next_o
);
  import smx_pkg::*;

  word_t stk_q [STACK_DEPTH];
  word_t stk_d [STACK_DEPTH];
  cnt_t  cnt_q;
  cnt_t  cnt_d;

  always_comb begin
    stk_d = stk_q;
    cnt_d = cnt_q;
    case (cmd_i.op)
      STK_PUSH: begin
        stk_d[0] = cmd_i.val;
        for (int i = 1; i < STACK_DEPTH; i++) begin
          stk_d[i] = stk_q[i-1];
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      STK_POP1: begin
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
          stk_d[i] = stk_q[i+1];
        end
        cnt_d = cnt_q - CNT_W'(1);
      end
      STK_POP2: begin
        for (int i = 0; i < STACK_DEPTH - 2; i++) begin
          stk_d[i] = stk_q[i+2];
        end
        cnt_d = cnt_q - CNT_W'(2);
      end
      STK_REPL: begin
        stk_d[0] = cmd_i.val;
      end
      STK_MERGE: begin
        stk_d[0] = cmd_i.val;
        for (int i = 1; i < STACK_DEPTH - 1; i++) begin
          stk_d[i] = stk_q[i+1];
        end
        cnt_d = cnt_q - CNT_W'(1);
      end
      default: begin
        stk_d = stk_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    stk_q <= stk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign top_o      = stk_q[0];
  assign second_o   = stk_q[1];
  assign cnt_o      = cnt_q;
  assign top_next_o = stk_d[0];
  assign cnt_next_o = cnt_d;

endmodule

// ===== hdl/stack_machine_executor.sv =====
// flow: an accepted item is executed while it sits in the input register and
// the output can advance; its result beat is offered from the next edge on
// throughput: one item per cycle while the output is not stalled; the stack
// is a shift-register array; the memory read address follows the next top
// reset: stack empty, skip counter and halted flag cleared, data memory reads
// as zero through per-word valid bits, so items are taken right after reset
module stack_machine_executor (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [smx_pkg::OPC_W-1:0]             opcode_i,
  input  logic signed [smx_pkg::OPND_W-1:0]     operand_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [smx_pkg::STAT_W-1:0]            status_o,
  output logic signed [smx_pkg::TOP_W-1:0]      top_value_o,
  output logic [smx_pkg::CNT_W-1:0]             depth_o
);
  import smx_pkg::*;

  logic                     inq_valid_q;
  logic [OPC_W-1:0]         opcode_q;
  logic signed [OPND_W-1:0] operand_q;

  logic                     halted_q, halted_d;
  logic [SKIP_W-1:0]        skip_q, skip_d;

  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic [TOP_W-1:0]         top_q, top_d;
  cnt_t                     depth_q;

  logic                     adv;
  logic                     exec;
  logic                     in_acc;

  stk_cmd_t                 scmd;
  mem_wr_t                  mwr;
  word_t                    s_top, s_second, s_top_next, mem_rdata;
  cnt_t                     s_cnt, s_cnt_next;
  logic                     bad_addr;

  assign adv    = !out_valid_q || !out_stall_i;
  assign exec   = inq_valid_q && adv;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = inq_valid_q && !adv;

  smx_stack u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (scmd),
    .top_o     (s_top),
    .second_o  (s_second),
    .cnt_o     (s_cnt),
    .top_next_o(s_top_next),
    .cnt_next_o(s_cnt_next)
  );

  // read address follows the next stack top so the word is ready for a load
  smx_dmem u_dmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (mwr),
    .raddr_i(s_top_next[MEM_AW-1:0]),
    .rdata_o(mem_rdata)
  );

  assign bad_addr = s_top[DATA_WIDTH-1] || (s_top >= MEM_LIMIT);

  always_comb begin
    scmd.op   = STK_HOLD;
    scmd.val  = s_top;
    mwr.we    = 1'b0;
    mwr.addr  = s_top[MEM_AW-1:0];
    mwr.data  = s_second;
    halted_d  = halted_q;
    skip_d    = skip_q;
    status_d  = ST_OK;
    if (exec) begin
      if (halted_q) begin
        status_d = ST_IGNORED;
      end else if (skip_q != '0) begin
        skip_d   = skip_q - SKIP_W'(1);
        status_d = ST_SKIPPED;
      end else begin
        case (opcode_e'(opcode_q))
          OP_HALT: begin
            halted_d = 1'b1;
            status_d = ST_HALTED;
          end
          OP_ADD, OP_NOR: begin
            if (s_cnt < CNT_W'(2)) begin
              status_d = ST_UNDERFLOW;
            end else begin
              scmd.op  = STK_MERGE;
              scmd.val = (opcode_e'(opcode_q) == OP_ADD) ? (s_top + s_second)
                                                         : ~(s_top | s_second);
            end
          end
          OP_IFZ: begin
            if (s_cnt == '0) begin
              status_d = ST_UNDERFLOW;
            end else begin
              scmd.op = STK_POP1;
              if (s_top == '0 && !operand_q[OPND_W-1]) begin
                skip_d = operand_q[SKIP_W-1:0];
              end
            end
          end
          OP_LOAD: begin
            if (s_cnt == '0) begin
              status_d = ST_UNDERFLOW;
            end else if (bad_addr) begin
              status_d = ST_BADADDR;
            end else begin
              scmd.op  = STK_REPL;
              scmd.val = mem_rdata;
            end
          end
          OP_STORE: begin
            if (s_cnt < CNT_W'(2)) begin
              status_d = ST_UNDERFLOW;
            end else if (bad_addr) begin
              status_d = ST_BADADDR;
            end else begin
              mwr.we  = 1'b1;
              scmd.op = STK_POP2;
            end
          end
          OP_POP: begin
            if (s_cnt == '0) begin
              status_d = ST_UNDERFLOW;
            end else begin
              scmd.op = STK_POP1;
            end
          end
          OP_PUSHI: begin
            if (s_cnt >= STACK_FULL) begin
              status_d = ST_OVERFLOW;
            end else begin
              scmd.op  = STK_PUSH;
              scmd.val = DATA_WIDTH'(operand_q);
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
    end
  end

  assign top_d = (s_cnt_next != '0) ? s_top_next[TOP_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      halted_q    <= 1'b0;
      skip_q      <= '0;
    end else begin
      if (in_acc) begin
        inq_valid_q <= 1'b1;
      end else if (exec) begin
        inq_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= exec;
      end
      halted_q <= halted_d;
      skip_q   <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      opcode_q  <= opcode_i;
      operand_q <= operand_i;
    end
    if (exec) begin
      status_q <= status_d;
      top_q    <= top_d;
      depth_q  <= s_cnt_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign top_value_o = top_q;
  assign depth_o     = depth_q;

endmodule
